// ===== hdl/iir_df_pkg.sv =====
// Shared types, constants and register codes for the direct-form-I IIR filter.
`default_nettype none

package iir_df_pkg;

    // Default values for the top-level parameters.
    localparam int FF_TAPS_DEF        = 4;
    localparam int FB_TAPS_DEF        = 3;
    localparam int SAMPLE_BITS_DEF    = 16;
    localparam int COEF_FRAC_BITS_DEF = 14;

    // Fixed storage sizes: four feedforward and three feedback coefficients.
    localparam int COEF_BITS    = 16;
    localparam int FF_MAX       = 4;
    localparam int FB_MAX       = 3;
    localparam int HIST_DEPTH   = 3;
    localparam int CFG_IDX_BITS = 3;

    typedef logic signed [COEF_BITS-1:0] t_coef;

    // The whole coefficient set; a[0] holds a1, a[2] holds a3.
    typedef struct packed {
        t_coef [FF_MAX-1:0] b;
        t_coef [FB_MAX-1:0] a;
    } t_coef_set;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_COEF_B0 = 3'd0,
        REG_COEF_B1 = 3'd1,
        REG_COEF_B2 = 3'd2,
        REG_COEF_B3 = 3'd3,
        REG_COEF_A1 = 3'd4,
        REG_COEF_A2 = 3'd5,
        REG_COEF_A3 = 3'd6
    } t_reg_idx;

    // Reset values: b0 = 0.5, b1 = 0.25, a1 = -0.75 in Q1.14.
    localparam t_coef COEF_B0_RST = 16'sd8192;
    localparam t_coef COEF_B1_RST = 16'sd4096;
    localparam t_coef COEF_B2_RST = 16'sd0;
    localparam t_coef COEF_B3_RST = 16'sd0;
    localparam t_coef COEF_A1_RST = -16'sd12288;
    localparam t_coef COEF_A2_RST = 16'sd0;
    localparam t_coef COEF_A3_RST = 16'sd0;

endpackage

`default_nettype wire

// ===== hdl/iir_df_in_if.sv =====
// Input sample channel: valid/ready handshake with the sample and stream flag.
`default_nettype none

interface iir_df_in_if #(
    parameter int SAMPLE_BITS = iir_df_pkg::SAMPLE_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_in;
    logic                          first_of_stream;

    modport source (output valid, output sample_in, output first_of_stream, input ready);
    modport sink   (input valid, input sample_in, input first_of_stream, output ready);
endinterface

`default_nettype wire

// ===== hdl/iir_df_out_if.sv =====
// Output sample channel: valid/ready handshake with the filtered sample and clip flag.
`default_nettype none

interface iir_df_out_if #(
    parameter int SAMPLE_BITS = iir_df_pkg::SAMPLE_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_out;
    logic                          saturated;

    modport source (output valid, output sample_out, output saturated, input ready);
    modport sink   (input valid, input sample_out, input saturated, output ready);
endinterface

`default_nettype wire

// ===== hdl/iir_df_coef_regs.sv =====
// Coefficient register bank written through the configuration port.
`default_nettype none

module iir_df_coef_regs (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic [iir_df_pkg::CFG_IDX_BITS-1:0] i_cfg_idx,
    input  wire logic [iir_df_pkg::COEF_BITS-1:0]    i_cfg_data,
    output      iir_df_pkg::t_coef_set               o_coef
);
    import iir_df_pkg::*;

    t_coef_set r_coef;

    // Register write decode; indexes beyond the list are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef.b[0] <= COEF_B0_RST;
            r_coef.b[1] <= COEF_B1_RST;
            r_coef.b[2] <= COEF_B2_RST;
            r_coef.b[3] <= COEF_B3_RST;
            r_coef.a[0] <= COEF_A1_RST;
            r_coef.a[1] <= COEF_A2_RST;
            r_coef.a[2] <= COEF_A3_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_COEF_B0: r_coef.b[0] <= i_cfg_data;
                REG_COEF_B1: r_coef.b[1] <= i_cfg_data;
                REG_COEF_B2: r_coef.b[2] <= i_cfg_data;
                REG_COEF_B3: r_coef.b[3] <= i_cfg_data;
                REG_COEF_A1: r_coef.a[0] <= i_cfg_data;
                REG_COEF_A2: r_coef.a[1] <= i_cfg_data;
                REG_COEF_A3: r_coef.a[2] <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign o_coef = r_coef;

endmodule

`default_nettype wire

// ===== hdl/iir_df_datapath.sv =====
// Sample histories and the single-pass multiply, sum, round and saturate datapath.
`default_nettype none

module iir_df_datapath #(
    parameter int FF_TAPS        = iir_df_pkg::FF_TAPS_DEF,
    parameter int FB_TAPS        = iir_df_pkg::FB_TAPS_DEF,
    parameter int SAMPLE_BITS    = iir_df_pkg::SAMPLE_BITS_DEF,
    parameter int COEF_FRAC_BITS = iir_df_pkg::COEF_FRAC_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire iir_df_pkg::t_coef_set         i_coef,
    input  wire logic                          i_adv,
    input  wire logic signed [SAMPLE_BITS-1:0] i_sample,
    input  wire logic                          i_first,
    output      logic signed [SAMPLE_BITS-1:0] o_y,
    output      logic                          o_sat
);
    import iir_df_pkg::*;

    localparam int PROD_W = COEF_BITS + SAMPLE_BITS;
    // Seven products need three guard bits; rounding fits in the headroom.
    localparam int ACC_W  = PROD_W + 3;
    localparam logic signed [ACC_W-1:0] MAX_V =
        ACC_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
    localparam logic signed [ACC_W-1:0] MIN_V = -MAX_V - ACC_W'(1);
    localparam logic signed [ACC_W-1:0] HALF_LSB =
        ACC_W'(64'sd1 <<< (COEF_FRAC_BITS - 1));

    logic signed [SAMPLE_BITS-1:0] r_x_hist [HIST_DEPTH];
    logic signed [SAMPLE_BITS-1:0] r_y_hist [HIST_DEPTH];

    logic signed [SAMPLE_BITS-1:0] ff_x    [FF_MAX];
    logic signed [SAMPLE_BITS-1:0] fb_y    [FB_MAX];
    logic signed [PROD_W-1:0]      ff_prod [FF_MAX];
    logic signed [PROD_W-1:0]      fb_prod [FB_MAX];
    logic signed [ACC_W-1:0]       acc;
    logic signed [ACC_W-1:0]       rounded;
    logic signed [ACC_W-1:0]       shifted;

    // Tap selection; a first-of-stream sample sees zero history.
    always_comb begin
        ff_x[0] = i_sample;
        for (int k = 1; k < FF_MAX; k++) begin
            ff_x[k] = i_first ? '0 : r_x_hist[k-1];
        end
        for (int k = 0; k < FB_MAX; k++) begin
            fb_y[k] = i_first ? '0 : r_y_hist[k];
        end
    end

    // Seven parallel products.
    always_comb begin
        for (int k = 0; k < FF_MAX; k++) begin
            ff_prod[k] = $signed(i_coef.b[k]) * ff_x[k];
        end
        for (int k = 0; k < FB_MAX; k++) begin
            fb_prod[k] = $signed(i_coef.a[k]) * fb_y[k];
        end
    end

    // Sum of the active taps; feedback terms are subtracted.
    always_comb begin
        acc = '0;
        for (int k = 0; k < FF_MAX; k++) begin
            if (k < FF_TAPS) begin
                acc = acc + ACC_W'(ff_prod[k]);
            end
        end
        for (int k = 0; k < FB_MAX; k++) begin
            if (k < FB_TAPS) begin
                acc = acc - ACC_W'(fb_prod[k]);
            end
        end
    end

    // Round to nearest with ties upward, then clip to the sample range.
    always_comb begin
        rounded = acc + HALF_LSB;
        shifted = rounded >>> COEF_FRAC_BITS;
        if (shifted > MAX_V) begin
            o_y   = MAX_V[SAMPLE_BITS-1:0];
            o_sat = 1'b1;
        end else if (shifted < MIN_V) begin
            o_y   = MIN_V[SAMPLE_BITS-1:0];
            o_sat = 1'b1;
        end else begin
            o_y   = shifted[SAMPLE_BITS-1:0];
            o_sat = 1'b0;
        end
    end

    // History shift when a sample moves on; a new stream restarts from zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < HIST_DEPTH; k++) begin
                r_x_hist[k] <= '0;
                r_y_hist[k] <= '0;
            end
        end else if (i_adv) begin
            r_x_hist[0] <= i_sample;
            r_y_hist[0] <= o_y;
            for (int k = 1; k < HIST_DEPTH; k++) begin
                r_x_hist[k] <= i_first ? '0 : r_x_hist[k-1];
                r_y_hist[k] <= i_first ? '0 : r_y_hist[k-1];
            end
        end
    end

endmodule

`default_nettype wire

// ===== hdl/iir_direct_form_filter_core.sv =====
// Top level of the direct-form-I IIR filter: input register, datapath, result register.
//
//  Channel  Direction  Handshake          Contents
//  i_in     in         valid / ready      sample_in, first_of_stream
//  o_out    out        valid / ready      sample_out, saturated
//  i_cfg_*  in         write enable only  register index, 16-bit coefficient
//
// One sample is accepted per cycle while results are read; each result is then registered.
// The rate is set by the feedback loop: seven multipliers, the tap sum, rounding and
// clipping all lie between the input register and the history and result registers.
// Synchronous reset restores default coefficients, zeroes both histories and empties
// both registers. A stalled result holds in the output register while one further
// request waits in the input register; only then does i_in.ready fall.
`default_nettype none

module iir_direct_form_filter_core #(
    parameter int FF_TAPS        = iir_df_pkg::FF_TAPS_DEF,
    parameter int FB_TAPS        = iir_df_pkg::FB_TAPS_DEF,
    parameter int SAMPLE_BITS    = iir_df_pkg::SAMPLE_BITS_DEF,
    parameter int COEF_FRAC_BITS = iir_df_pkg::COEF_FRAC_BITS_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic [iir_df_pkg::CFG_IDX_BITS-1:0] i_cfg_idx,
    input  wire logic [iir_df_pkg::COEF_BITS-1:0]    i_cfg_data,
    iir_df_in_if.sink                                i_in,
    iir_df_out_if.source                             o_out
);
    import iir_df_pkg::*;

    localparam logic signed [SAMPLE_BITS-1:0] Y_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] Y_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    t_coef_set                     coef;
    logic                          adv;
    logic                          in_take;
    logic signed [SAMPLE_BITS-1:0] dp_y;
    logic                          dp_sat;

    logic                          r_in_valid;
    logic signed [SAMPLE_BITS-1:0] r_in_sample;
    logic                          r_in_first;
    logic                          r_out_valid;
    logic signed [SAMPLE_BITS-1:0] r_out_sample;
    logic                          r_out_sat;

    iir_df_coef_regs u_coef_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_coef     (coef)
    );

    iir_df_datapath #(
        .FF_TAPS        (FF_TAPS),
        .FB_TAPS        (FB_TAPS),
        .SAMPLE_BITS    (SAMPLE_BITS),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_coef   (coef),
        .i_adv    (adv),
        .i_sample (r_in_sample),
        .i_first  (r_in_first),
        .o_y      (dp_y),
        .o_sat    (dp_sat)
    );

    // Pipeline flow: the held sample moves on when the result register is free or being read.
    assign adv        = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || adv;
    assign in_take    = i_in.valid && i_in.ready;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_sample <= i_in.sample_in;
            r_in_first  <= i_in.first_of_stream;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_sample <= dp_y;
            r_out_sat    <= dp_sat;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.sample_out = r_out_sample;
    assign o_out.saturated  = r_out_sat;

    // A sample that moves on always leaves a valid result behind it.
    a_adv_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv |=> r_out_valid)
        else $error("result register empty after a sample moved on");

    // An accepted request is held in the input register on the next cycle.
    a_take_fills_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_take |=> r_in_valid)
        else $error("accepted request lost");

    // A blocked sample keeps its value while it waits.
    a_in_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !adv |=> r_in_valid && $stable(r_in_sample) && $stable(r_in_first))
        else $error("waiting input sample changed");

    // A clipped result sits at one of the range limits.
    a_sat_at_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_sat |-> (r_out_sample == Y_MAX) || (r_out_sample == Y_MIN))
        else $error("saturated flag set on a result inside the range");

endmodule

`default_nettype wire

// ===== tb/sv/iir_df_checker.sv =====
// Checker for the IIR filter: watches both channels, predicts each result and compares it.
`timescale 1ns / 1ps

module iir_df_checker
    import iir_df_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_cfg_we,
    input  wire logic [CFG_IDX_BITS-1:0] i_cfg_idx,
    input  wire logic [COEF_BITS-1:0]    i_cfg_data,
    iir_df_in_if                         i_in_ch,
    iir_df_out_if                        i_out_ch,
    output int                           o_fail_count,
    output int                           o_outstanding
);

    localparam int SB       = SAMPLE_BITS_DEF;
    localparam int FRAC     = COEF_FRAC_BITS_DEF;
    localparam int ACC_BITS = 48;

    typedef logic signed [SB-1:0]       t_sample;
    typedef logic signed [ACC_BITS-1:0] t_acc;

    typedef struct packed {
        t_sample sample_out;
        logic    saturated;
    } t_filt_out;

    localparam t_acc SAT_HI = (t_acc'(1) <<< (SB - 1)) - t_acc'(1);
    localparam t_acc SAT_LO = -(t_acc'(1) <<< (SB - 1));
    localparam t_acc ROUND_HALF = t_acc'(1) <<< (FRAC - 1);

    // Local copy of the coefficients and of both delay lines.
    t_coef     tap_b [FF_MAX];
    t_coef     tap_a [FB_MAX];
    t_sample   x_hist [HIST_DEPTH];
    t_sample   y_hist [HIST_DEPTH];
    t_filt_out filtered_q [$];
    int        mismatches = 0;

    function automatic void clear_history();
        for (int k = 0; k < HIST_DEPTH; k++) begin
            x_hist[k] = '0;
            y_hist[k] = '0;
        end
    endfunction

    // Mirror a coefficient write; indexes beyond the last register are dropped.
    function automatic void write_coef(input logic [CFG_IDX_BITS-1:0] idx, input t_coef value);
        case (idx)
            REG_COEF_B0: tap_b[0] = value;
            REG_COEF_B1: tap_b[1] = value;
            REG_COEF_B2: tap_b[2] = value;
            REG_COEF_B3: tap_b[3] = value;
            REG_COEF_A1: tap_a[0] = value;
            REG_COEF_A2: tap_a[1] = value;
            REG_COEF_A3: tap_a[2] = value;
            default: ;
        endcase
    endfunction

    // One filter step: exact tap sum, round half up, clip, then shift the delay lines.
    function automatic t_filt_out filter_step(input t_sample x, input logic first);
        t_acc      acc;
        t_acc      rounded;
        t_filt_out res;
        if (first)
            clear_history();
        acc = t_acc'(tap_b[0]) * t_acc'(x);
        for (int k = 1; k < FF_MAX; k++)
            acc += t_acc'(tap_b[k]) * t_acc'(x_hist[k-1]);
        for (int k = 0; k < FB_MAX; k++)
            acc -= t_acc'(tap_a[k]) * t_acc'(y_hist[k]);
        rounded = (acc + ROUND_HALF) >>> FRAC;
        res.saturated = 1'b0;
        if (rounded > SAT_HI) begin
            rounded       = SAT_HI;
            res.saturated = 1'b1;
        end else if (rounded < SAT_LO) begin
            rounded       = SAT_LO;
            res.saturated = 1'b1;
        end
        res.sample_out = t_sample'(rounded);
        for (int k = HIST_DEPTH - 1; k > 0; k--) begin
            x_hist[k] = x_hist[k-1];
            y_hist[k] = y_hist[k-1];
        end
        x_hist[0] = x;
        y_hist[0] = res.sample_out;
        return res;
    endfunction

    // A result leaving the block is matched against the oldest prediction.
    function automatic void check_result(input t_sample got_sample, input logic got_sat);
        t_filt_out want;
        if (filtered_q.size() == 0) begin
            $error("result with no request outstanding: sample_out %0d, saturated %0b",
                   got_sample, got_sat);
            mismatches++;
            return;
        end
        want = filtered_q.pop_front();
        if (got_sample !== want.sample_out) begin
            $error("sample_out mismatch: expected %0d, actual %0d", want.sample_out, got_sample);
            mismatches++;
        end
        if (got_sat !== want.saturated) begin
            $error("saturated mismatch: expected %0b, actual %0b", want.saturated, got_sat);
            mismatches++;
        end
    endfunction

    // Everything is sampled at the rising edge, as the block sees it.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            tap_b[0] = COEF_B0_RST;
            tap_b[1] = COEF_B1_RST;
            tap_b[2] = COEF_B2_RST;
            tap_b[3] = COEF_B3_RST;
            tap_a[0] = COEF_A1_RST;
            tap_a[1] = COEF_A2_RST;
            tap_a[2] = COEF_A3_RST;
            clear_history();
            filtered_q.delete();
        end else begin
            if (i_cfg_we)
                write_coef(i_cfg_idx, i_cfg_data);
            if (i_out_ch.valid && i_out_ch.ready)
                check_result(i_out_ch.sample_out, i_out_ch.saturated);
            if (i_in_ch.valid && i_in_ch.ready)
                filtered_q.push_back(filter_step(i_in_ch.sample_in, i_in_ch.first_of_stream));
        end
        o_outstanding <= filtered_q.size();
        o_fail_count  <= mismatches;
    end

endmodule

// ===== tb/sv/tb.sv =====
// Testbench top for the IIR filter core: clock, reset, stimulus, back-pressure and verdict.
`timescale 1ns / 1ps

module tb;
    import iir_df_pkg::*;

    localparam int SB                = SAMPLE_BITS_DEF;
    localparam int RESET_CYCLES      = 8;
    localparam int CYCLE_LIMIT       = 200000;
    localparam int RANDOM_PHASES     = 10;
    localparam int SAMPLES_PER_PHASE = 125;
    localparam int HOLD_OFF_PHASE    = 4;
    localparam int HOLD_OFF_CYCLES   = 80;
    localparam int SETTLE_CYCLES     = 8;

    localparam logic [CFG_IDX_BITS-1:0] REG_IDX_SPARE = 3'd7;

    typedef logic signed [SB-1:0] t_sample;

    localparam t_sample SAMPLE_MAX = 16'sh7FFF;
    localparam t_sample SAMPLE_MIN = 16'sh8000;

    typedef enum int {
        COEF_FULL,
        COEF_MILD,
        COEF_EXTREME,
        COEF_DEFAULT
    } t_coef_style;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n;
    logic                    cfg_we;
    logic [CFG_IDX_BITS-1:0] cfg_idx;
    logic [COEF_BITS-1:0]    cfg_data;
    logic                    quiet;
    logic                    hold_off_req;
    int                      fail_count;
    int                      outstanding;
    int unsigned             cycle_count = 0;
    int unsigned             sent_count  = 0;

    iir_df_in_if  in_ch ();
    iir_df_out_if out_ch ();

    iir_direct_form_filter_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    iir_df_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_idx     (cfg_idx),
        .i_cfg_data    (cfg_data),
        .i_in_ch       (in_ch),
        .i_out_ch      (out_ch),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    // 50 MHz clock.
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Result side: short random stalls, one long hold-off on request, none when quiet.
    initial begin : result_sink
        int unsigned stall_left;
        int unsigned beat;
        bit          hold_off_done;
        stall_left    = 0;
        beat          = 0;
        hold_off_done = 1'b0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            beat++;
            if (stall_left != 0) begin
                out_ch.ready <= 1'b0;
                stall_left--;
            end else if (hold_off_req && !hold_off_done) begin
                hold_off_done = 1'b1;
                stall_left    = HOLD_OFF_CYCLES - 1;
                out_ch.ready <= 1'b0;
            end else if (!quiet && (beat / 256) % 4 != 3 && $urandom_range(0, 5) == 0) begin
                stall_left    = $urandom_range(0, 4);
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // Offer one request, possibly after a short gap, and wait until it is taken.
    task automatic offer_sample(input t_sample value, input logic first);
        int unsigned gap;
        gap = 0;
        if (!quiet && (sent_count / 64) % 3 != 2 && $urandom_range(0, 5) == 0)
            gap = $urandom_range(1, 5);
        if (gap != 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid           <= 1'b1;
        in_ch.sample_in       <= value;
        in_ch.first_of_stream <= first;
        do @(posedge i_clk); while (!in_ch.ready);
        sent_count++;
    endtask

    // Stop offering and wait until every predicted result has come out.
    task automatic drain_filter();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0)
            @(posedge i_clk);
    endtask

    // Drive one register write; the caller lowers the write enable afterwards.
    task automatic put_reg(input logic [CFG_IDX_BITS-1:0] idx, input t_coef value);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value;
        @(posedge i_clk);
    endtask

    // Write all seven coefficients back to back, optionally followed by the unused index.
    task automatic load_coefs(input t_coef_set cs, input bit with_spare);
        put_reg(REG_COEF_B0, cs.b[0]);
        put_reg(REG_COEF_B1, cs.b[1]);
        put_reg(REG_COEF_B2, cs.b[2]);
        put_reg(REG_COEF_B3, cs.b[3]);
        put_reg(REG_COEF_A1, cs.a[0]);
        put_reg(REG_COEF_A2, cs.a[1]);
        put_reg(REG_COEF_A3, cs.a[2]);
        if (with_spare)
            put_reg(REG_IDX_SPARE, t_coef'($urandom));
        cfg_we <= 1'b0;
    endtask

    function automatic t_coef pick_coef(input t_coef_style style);
        case (style)
            COEF_MILD: return t_coef'($urandom_range(0, 8191)) - 16'sd4096;
            COEF_EXTREME: begin
                case ($urandom_range(0, 4))
                    0: return 16'sh8000;
                    1: return 16'sh7FFF;
                    2: return 16'sh0000;
                    3: return 16'shFFFF;
                    default: return 16'sh0001;
                endcase
            end
            default: return t_coef'($urandom);
        endcase
    endfunction

    function automatic t_coef_set make_coef_set(input t_coef_style style);
        t_coef_set cs;
        if (style == COEF_DEFAULT) begin
            cs.b[0] = COEF_B0_RST;
            cs.b[1] = COEF_B1_RST;
            cs.b[2] = COEF_B2_RST;
            cs.b[3] = COEF_B3_RST;
            cs.a[0] = COEF_A1_RST;
            cs.a[1] = COEF_A2_RST;
            cs.a[2] = COEF_A3_RST;
        end else begin
            for (int k = 0; k < FF_MAX; k++)
                cs.b[k] = pick_coef(style);
            for (int k = 0; k < FB_MAX; k++)
                cs.a[k] = pick_coef(style);
        end
        return cs;
    endfunction

    // Mostly full-range samples, with some extremes and some values near zero.
    function automatic t_sample random_sample();
        case ($urandom_range(0, 7))
            0: return ($urandom_range(0, 1) != 0) ? SAMPLE_MAX : SAMPLE_MIN;
            1: return t_sample'($urandom_range(0, 63)) - t_sample'(32);
            default: return t_sample'($urandom);
        endcase
    endfunction

    // Main sequence: reset, directed requests, then random phases with fresh coefficients.
    initial begin : stimulus
        t_coef_set cs;
        in_ch.valid           <= 1'b0;
        in_ch.sample_in       <= '0;
        in_ch.first_of_stream <= 1'b0;
        cfg_we                <= 1'b0;
        cfg_idx               <= REG_COEF_B0;
        cfg_data              <= '0;
        quiet                 <= 1'b0;
        hold_off_req          <= 1'b0;
        i_rst_n               <= 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset coefficients: climb into positive and negative clipping, then small values.
        offer_sample(SAMPLE_MAX, 1'b1);
        offer_sample(SAMPLE_MAX, 1'b0);
        offer_sample(SAMPLE_MAX, 1'b0);
        offer_sample(SAMPLE_MAX, 1'b0);
        offer_sample(SAMPLE_MIN, 1'b0);
        offer_sample(SAMPLE_MIN, 1'b0);
        offer_sample(SAMPLE_MIN, 1'b0);
        offer_sample(16'sh0000, 1'b1);
        offer_sample(16'shFFFF, 1'b0);
        offer_sample(16'sh0001, 1'b0);
        offer_sample(16'sh5555, 1'b0);
        offer_sample(16'shAAAA, 1'b0);
        drain_filter();

        // Extreme coefficients; the write to the unused index must change nothing.
        cs.b[0] = 16'sh7FFF;
        cs.b[1] = 16'sh8000;
        cs.b[2] = 16'sh7FFF;
        cs.b[3] = 16'sh8000;
        cs.a[0] = 16'sh7FFF;
        cs.a[1] = 16'sh8000;
        cs.a[2] = 16'sh7FFF;
        load_coefs(cs, 1'b1);
        offer_sample(SAMPLE_MAX, 1'b1);
        offer_sample(SAMPLE_MIN, 1'b0);
        offer_sample(16'sh0000, 1'b0);
        offer_sample(16'sh0001, 1'b0);
        drain_filter();

        // Unit b0 only: the first four sums land exactly on half steps, so ties round upwards.
        cs.b[0] = 16'sh0001;
        cs.b[1] = '0;
        cs.b[2] = '0;
        cs.b[3] = '0;
        cs.a[0] = '0;
        cs.a[1] = '0;
        cs.a[2] = '0;
        load_coefs(cs, 1'b0);
        offer_sample(16'sh2000, 1'b1);
        offer_sample(-16'sh2000, 1'b0);
        offer_sample(16'sh6000, 1'b0);
        offer_sample(-16'sh6000, 1'b0);
        offer_sample(SAMPLE_MIN, 1'b0);
        offer_sample(SAMPLE_MAX, 1'b0);

        // Random phases; the long hold-off falls mid-run and the last phase runs without gaps.
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            drain_filter();
            if (phase == RANDOM_PHASES - 1)
                quiet <= 1'b1;
            load_coefs(make_coef_set(t_coef_style'(phase % 4)), $urandom_range(0, 2) == 0);
            if (phase == HOLD_OFF_PHASE)
                hold_off_req <= 1'b1;
            for (int n = 0; n < SAMPLES_PER_PHASE; n++)
                offer_sample(random_sample(), $urandom_range(0, 39) == 0);
        end

        drain_filter();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && outstanding == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
